// ----- design/npcm_pkg.sv -----
package npcm_pkg;

	// fixed field widths
	localparam int CHAN_W  = 8;
	localparam int COLOR_W = 24;
	localparam int DIST_W  = 18;
	localparam int SLOT_W  = 4;
	localparam int CFG_W   = 5;
	localparam int OUT_IDX_W = 4;
	localparam int BUILTIN_COLORS = 16;

	// reset value of the entries count register
	localparam logic [CFG_W-1:0] ENTRIES_RESET = 5'd16;

	// operation codes carried in tuser
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_MATCH = 1'b1;

	// largest possible squared distance, three channels of 255
	localparam logic [DIST_W-1:0] DIST_MAX = 18'd195075;

	// control that travels down the distance pipeline with each entry
	typedef struct packed {
		logic vld;
		logic last;
	} npcm_ctrl_t;

	// built-in palette contents after reset
	function automatic logic [COLOR_W-1:0] reset_color(input logic [3:0] idx);
		logic [COLOR_W-1:0] c;
		begin
			unique case (idx)
				4'd0:    c = 24'hB0506B;
				4'd1:    c = 24'h91287B;
				4'd2:    c = 24'h581B7E;
				4'd3:    c = 24'h282976;
				4'd4:    c = 24'h2078A3;
				4'd5:    c = 24'h146970;
				4'd6:    c = 24'h3F4D1C;
				4'd7:    c = 24'h4D8913;
				4'd8:    c = 24'hBA840F;
				4'd9:    c = 24'hB84C00;
				4'd10:   c = 24'h7D1B19;
				4'd11:   c = 24'h55341A;
				4'd12:   c = 24'h06080B;
				4'd13:   c = 24'h313232;
				4'd14:   c = 24'h6D6A5C;
				default: c = 24'hB1B0A6;
			endcase
			return c;
		end
	endfunction

	// signed q2.14 to 8-bit channel: floor(v * 255 / 16384), clamped to 0..255
	function automatic logic [CHAN_W-1:0] q214_to_byte(input logic [15:0] v);
		logic [23:0] prod;
		logic [9:0]  scaled;
		logic [CHAN_W-1:0] res;
		begin
			prod   = 24'(v) * 24'd255;
			scaled = prod[23:14];
			if (v[15]) begin
				res = '0;
			end else if (scaled > 10'd255) begin
				res = 8'hFF;
			end else begin
				res = scaled[7:0];
			end
			return res;
		end
	endfunction

endpackage

// ----- design/npcm_palette.sv -----
module npcm_palette #(
	parameter int PALETTE_DEPTH = 16,
	parameter int IDX_W = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [npcm_pkg::SLOT_W-1:0]      wr_slot,
	input  logic [npcm_pkg::COLOR_W-1:0]     wr_color,
	input  logic                             rd_en,
	input  logic [IDX_W-1:0]                 rd_addr,
	output logic [npcm_pkg::COLOR_W-1:0]     rd_data_s1
);

	// only the first sixteen entries can ever be written, the rest stay zero
	localparam int WR_DEPTH = (PALETTE_DEPTH < npcm_pkg::BUILTIN_COLORS) ?
		PALETTE_DEPTH : npcm_pkg::BUILTIN_COLORS;
	localparam int WR_IDX_W = (WR_DEPTH > 1) ? $clog2(WR_DEPTH) : 1;

	logic [npcm_pkg::COLOR_W-1:0] mem_q [WR_DEPTH];
	logic [WR_DEPTH-1:0]          valid_q;
	logic [WR_IDX_W-1:0]          wr_idx;
	logic [WR_IDX_W-1:0]          rd_idx;
	logic                         wr_ok;

	assign wr_idx = WR_IDX_W'(wr_slot);
	assign rd_idx = WR_IDX_W'(rd_addr);
	assign wr_ok  = wr_en && (32'(wr_slot) < PALETTE_DEPTH);

	// written flags, an unwritten entry reads as its built-in color
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_ok) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	// storage write
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_q[wr_idx] <= wr_color;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (32'(rd_addr) >= WR_DEPTH) begin
				rd_data_s1 <= '0;
			end else if (valid_q[rd_idx]) begin
				rd_data_s1 <= mem_q[rd_idx];
			end else begin
				rd_data_s1 <= npcm_pkg::reset_color(4'(rd_addr));
			end
		end
	end

endmodule

// ----- design/npcm_dist.sv -----
module npcm_dist #(
	parameter int IDX_W = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  npcm_pkg::npcm_ctrl_t          ctrl_s1,
	input  logic [IDX_W-1:0]              idx_s1,
	input  logic [npcm_pkg::COLOR_W-1:0]  color_s1,
	input  logic [npcm_pkg::CHAN_W-1:0]   red_q,
	input  logic [npcm_pkg::CHAN_W-1:0]   green_q,
	input  logic [npcm_pkg::CHAN_W-1:0]   blue_q,
	output logic                          done_q,
	output logic [IDX_W-1:0]              best_idx_q,
	output logic [npcm_pkg::DIST_W-1:0]   best_dist_q
);

	function automatic logic [15:0] diff_sq(
		input logic [npcm_pkg::CHAN_W-1:0] a,
		input logic [npcm_pkg::CHAN_W-1:0] b
	);
		logic [npcm_pkg::CHAN_W-1:0] d;
		begin
			d = (a > b) ? (a - b) : (b - a);
			return 16'(d) * 16'(d);
		end
	endfunction

	npcm_pkg::npcm_ctrl_t        ctrl_s2;
	logic [IDX_W-1:0]            idx_s2;
	logic [npcm_pkg::DIST_W-1:0] dist_s2;
	logic [npcm_pkg::DIST_W-1:0] dist_s1;

	// squared distance of one palette entry
	assign dist_s1 = npcm_pkg::DIST_W'(diff_sq(red_q,   color_s1[23:16]))
		+ npcm_pkg::DIST_W'(diff_sq(green_q, color_s1[15:8]))
		+ npcm_pkg::DIST_W'(diff_sq(blue_q,  color_s1[7:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
			done_q  <= 1'b0;
		end else begin
			ctrl_s2 <= ctrl_s1;
			done_q  <= ctrl_s2.vld && ctrl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2  <= idx_s1;
		dist_s2 <= dist_s1;
	end

	// running minimum, strict compare keeps the lowest index on a tie
	always_ff @(posedge clk) begin
		if (clear) begin
			best_dist_q <= '1;
			best_idx_q  <= '0;
		end else if (ctrl_s2.vld && (dist_s2 < best_dist_q)) begin
			best_dist_q <= dist_s2;
			best_idx_q  <= idx_s2;
		end
	end

endmodule

// ----- design/nearest_palette_color_match_core.sv -----
// load: a load transfer writes its palette slot; N is the clamped entries count
// match: each of N entries passes the palette read, distance and minimum registers,
//   compared one per cycle by the single distance unit; a new match is taken while
//   idle, and a stalled result holds the next match
// reset: asynchronous, active low; palette returns to its sixteen built-in
//   colors at once (no clearing pass) and the entries count returns to 16
module nearest_palette_color_match_core #(
	parameter int PALETTE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// red_in[15:0], green_in[31:16], blue_in[47:32], entry_slot[51:48],
	// entry_color[75:52], zero fill [79:76]
	input  logic [79:0] s_tdata,
	// operation[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// best_index[3:0], best_distance_sq[21:4], zero fill [23:22]
	output logic [23:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data
);

	localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_OUT    = 2'd3;

	logic [1:0]                    state_q;
	logic [npcm_pkg::CFG_W-1:0]    entries_q;
	logic [CNT_W-1:0]              count;
	logic [CNT_W-1:0]              count_q;
	logic [IDX_W-1:0]              cnt_q;
	logic                          last_issue;
	logic [npcm_pkg::CHAN_W-1:0]   red_q;
	logic [npcm_pkg::CHAN_W-1:0]   green_q;
	logic [npcm_pkg::CHAN_W-1:0]   blue_q;
	logic                          in_xfer;
	logic                          match_start;
	logic                          load_wr;
	logic                          rd_en;
	npcm_pkg::npcm_ctrl_t          ctrl_s1;
	logic [IDX_W-1:0]              idx_s1;
	logic [npcm_pkg::COLOR_W-1:0]  color_s1;
	logic                          done;
	logic [IDX_W-1:0]              best_idx;
	logic [npcm_pkg::DIST_W-1:0]   best_dist;
	logic                          out_free;
	logic                          m_tvalid_q;
	logic [npcm_pkg::OUT_IDX_W-1:0] out_idx_q;
	logic [npcm_pkg::DIST_W-1:0]   out_dist_q;

	assign s_tready    = (state_q == ST_IDLE);
	assign in_xfer     = s_tvalid && s_tready;
	assign match_start = in_xfer && (s_tuser == npcm_pkg::OP_MATCH);
	assign load_wr     = in_xfer && (s_tuser == npcm_pkg::OP_LOAD);
	assign cfg_ready   = 1'b1;
	assign out_free    = !m_tvalid_q || m_tready;

	// entries register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= npcm_pkg::ENTRIES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			entries_q <= cfg_data;
		end
	end

	// clamp the entries count to 1..PALETTE_DEPTH
	always_comb begin
		priority if (entries_q == '0) begin
			count = CNT_W'(1);
		end else if (32'(entries_q) > PALETTE_DEPTH) begin
			count = CNT_W'(PALETTE_DEPTH);
		end else begin
			count = CNT_W'(entries_q);
		end
	end

	// channel conversion at the input transfer
	always_ff @(posedge clk) begin
		if (match_start) begin
			red_q   <= npcm_pkg::q214_to_byte(s_tdata[15:0]);
			green_q <= npcm_pkg::q214_to_byte(s_tdata[31:16]);
			blue_q  <= npcm_pkg::q214_to_byte(s_tdata[47:32]);
			count_q <= count;
		end
	end

	assign last_issue = (32'(cnt_q) + 1 == 32'(count_q));
	assign rd_en      = (state_q == ST_SEARCH);

	// search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (match_start) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					cnt_q <= cnt_q + IDX_W'(1);
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// control alongside the palette read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.vld  <= rd_en;
			ctrl_s1.last <= rd_en && last_issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
	end

	npcm_palette #(
		.PALETTE_DEPTH (PALETTE_DEPTH),
		.IDX_W         (IDX_W)
	) u_palette (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (load_wr),
		.wr_slot    (s_tdata[51:48]),
		.wr_color   (s_tdata[75:52]),
		.rd_en      (rd_en),
		.rd_addr    (cnt_q),
		.rd_data_s1 (color_s1)
	);

	npcm_dist #(
		.IDX_W (IDX_W)
	) u_dist (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (match_start),
		.ctrl_s1     (ctrl_s1),
		.idx_s1      (idx_s1),
		.color_s1    (color_s1),
		.red_q       (red_q),
		.green_q     (green_q),
		.blue_q      (blue_q),
		.done_q      (done),
		.best_idx_q  (best_idx),
		.best_dist_q (best_dist)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			out_idx_q  <= npcm_pkg::OUT_IDX_W'(best_idx);
			out_dist_q <= best_dist;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_dist_q, out_idx_q};

`ifndef SYNTHESIS
	// search pass ends only while draining
	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == ST_DRAIN))
		else $error("search finished outside drain");

	// a match transfer starts the search
	a_match_starts: assert property (@(posedge clk) disable iff (!arst_n)
		match_start |=> (state_q == ST_SEARCH))
		else $error("match transfer did not start a search");

	// the address counter stays inside the searched range
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (32'(cnt_q) < 32'(count_q)))
		else $error("search address beyond entries count");

	// the winning distance is a real distance
	a_dist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (best_dist <= npcm_pkg::DIST_MAX))
		else $error("best distance out of range");
`endif

endmodule
